[sv/ip6cs_pkg.sv]
// Shared types, constants and helpers for the IPv6 UDP/ICMPv6 checksum checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ip6cs_pkg;

    localparam int unsigned POS_W = 17;

    // Byte positions within the packet
    localparam logic [POS_W-1:0] POS_PLEN_HI    = 17'd4;
    localparam logic [POS_W-1:0] POS_PLEN_LO    = 17'd5;
    localparam logic [POS_W-1:0] POS_NEXT_HDR   = 17'd6;
    localparam logic [POS_W-1:0] ADDR_START     = 17'd8;
    localparam logic [POS_W-1:0] HDR_LEN        = 17'd40;
    localparam logic [POS_W-1:0] POS_UDP_LEN_HI = 17'd44;
    localparam logic [POS_W-1:0] POS_UDP_LEN_LO = 17'd45;
    localparam logic [POS_W-1:0] POS_MAX        = 17'h1FFFF;

    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP6   = 8'd58;

    // Checksum field offsets, as reported and as byte positions
    localparam logic [5:0]  UDP_CSUM_POS  = 6'd46;
    localparam logic [5:0]  ICMP_CSUM_POS = 6'd42;

    localparam logic [15:0] UDP_MIN_LEN   = 16'd8;
    localparam logic [15:0] ICMP_MIN_LEN  = 16'd4;
    localparam logic [15:0] SUM_ONES      = 16'hFFFF;
    localparam logic [15:0] SUM_ZERO      = 16'h0000;

    localparam logic [1:0]  ST_OK          = 2'd0;
    localparam logic [1:0]  ST_MISMATCH    = 2'd1;
    localparam logic [1:0]  ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0]  ST_TRUNCATED   = 2'd3;

    // Snapshot of the packet state taken on its last byte
    typedef struct packed {
        logic [15:0]      sum;
        logic [15:0]      ulen;
        logic [7:0]       proto;
        logic [15:0]      rsum;
        logic [POS_W:0]   total;
    } t_fin;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fill_value;
        logic [5:0]  fill_offset;
        logic        is_udp;
    } t_res;

    // Upper-layer length, floored so the header holding the checksum is covered
    function automatic logic [15:0] eff_length(input logic [7:0] proto,
                                               input logic [15:0] ulen);
        logic [15:0] m;
        m = (proto == PROTO_UDP) ? UDP_MIN_LEN : ICMP_MIN_LEN;
        return (ulen < m) ? m : ulen;
    endfunction

endpackage

`default_nettype wire

[sv/ip6cs_accum.sv]
// Per-byte stage: input register, packet state and ones'-complement running sum.
// Hands a snapshot of the state to the result stage on the last byte. Uses ip6cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ip6cs_accum (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [7:0]            i_byte,
    input  wire                  i_last,
    output logic                 o_fin_valid,
    input  wire                  i_fin_ready,
    output ip6cs_pkg::t_fin      o_fin
);
    import ip6cs_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_ulen, n_ulen;
    logic [15:0]      r_sum,  n_sum;
    logic [7:0]       r_held, n_held;
    logic [15:0]      r_rsum, n_rsum;

    logic             r_fin_valid;
    t_fin             r_fin;

    logic             w_step;
    logic             w_fin_free;
    logic             w_udp;
    logic             w_icmp;
    logic [POS_W-1:0] w_csum_pos;
    logic [POS_W-1:0] w_up_off;
    logic [15:0]      w_word;
    logic [16:0]      w_add;
    logic [15:0]      w_sum_add;

    assign w_fin_free = !r_fin_valid || i_fin_ready;
    // A last byte waits for the snapshot slot; other bytes never stall
    assign w_step     = r_in_valid && (!r_in_last || w_fin_free);
    assign o_ready    = !r_in_valid || w_step;

    assign w_udp      = (r_proto == PROTO_UDP);
    assign w_icmp     = (r_proto == PROTO_ICMP6);
    assign w_csum_pos = w_udp ? POS_W'(UDP_CSUM_POS) : POS_W'(ICMP_CSUM_POS);
    assign w_up_off   = r_pos - HDR_LEN;

    // Even positions are high bytes of a network-order word
    assign w_word    = r_pos[0] ? {8'd0, r_in_byte} : {r_in_byte, 8'd0};
    assign w_add     = {1'b0, r_sum} + {1'b0, w_word};
    assign w_sum_add = w_add[15:0] + {15'd0, w_add[16]};

    always_comb begin
        n_pos   = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;
        n_proto = r_proto;
        n_ulen  = r_ulen;
        n_sum   = r_sum;
        n_held  = r_held;
        n_rsum  = r_rsum;
        if (r_pos == POS_PLEN_HI) begin
            n_held = r_in_byte;
        end else if (r_pos == POS_PLEN_LO) begin
            n_ulen = {r_held, r_in_byte};
        end else if (r_pos == POS_NEXT_HDR) begin
            n_proto = r_in_byte;
        end else if (r_pos >= ADDR_START && r_pos < HDR_LEN) begin
            n_sum = w_sum_add;
        end else if (r_pos >= HDR_LEN && (w_udp || w_icmp)) begin
            if (w_udp && r_pos == POS_UDP_LEN_HI) begin
                n_held = r_in_byte;
            end else if (w_udp && r_pos == POS_UDP_LEN_LO) begin
                n_ulen = {r_held, r_in_byte};
            end
            // Capture the received checksum instead of summing it
            if (r_pos == w_csum_pos) begin
                n_rsum = {r_in_byte, r_rsum[7:0]};
            end else if (r_pos == w_csum_pos + POS_W'(1)) begin
                n_rsum = {r_rsum[15:8], r_in_byte};
            end else if (w_up_off < {1'b0, eff_length(r_proto, r_ulen)}) begin
                n_sum = w_sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_proto <= '0;
            r_ulen  <= '0;
            r_sum   <= '0;
            r_held  <= '0;
            r_rsum  <= '0;
        end else if (w_step) begin
            if (r_in_last) begin
                // Packet done: start the next one from a clean state
                r_pos   <= '0;
                r_proto <= '0;
                r_ulen  <= '0;
                r_sum   <= '0;
                r_held  <= '0;
                r_rsum  <= '0;
            end else begin
                r_pos   <= n_pos;
                r_proto <= n_proto;
                r_ulen  <= n_ulen;
                r_sum   <= n_sum;
                r_held  <= n_held;
                r_rsum  <= n_rsum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_fin_valid <= 1'b1;
        end else if (i_fin_ready) begin
            r_fin_valid <= 1'b0;
        end
        if (w_step && r_in_last) begin
            r_fin.sum   <= n_sum;
            r_fin.ulen  <= n_ulen;
            r_fin.proto <= n_proto;
            r_fin.rsum  <= n_rsum;
            r_fin.total <= {1'b0, r_pos} + (POS_W+1)'(1);
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

`default_nettype wire

[sv/ip6cs_result.sv]
// Result stage: adds the pseudo-header terms, forms and checks the checksum,
// and holds the result in the output register. Uses ip6cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ip6cs_result (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fin_valid,
    output logic                 o_fin_ready,
    input  ip6cs_pkg::t_fin      i_fin,
    output logic                 o_valid,
    input  wire                  i_ready,
    output ip6cs_pkg::t_res      o_res
);
    import ip6cs_pkg::*;

    logic        r_valid;
    t_res        r_res;
    t_res        n_res;

    logic        w_udp;
    logic        w_icmp;
    logic [15:0] w_eff;
    logic [17:0] w_sum3;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;
    logic [15:0] w_calc;
    logic        w_ok;

    assign o_fin_ready = !r_valid || i_ready;

    assign w_udp  = (i_fin.proto == PROTO_UDP);
    assign w_icmp = (i_fin.proto == PROTO_ICMP6);
    assign w_eff  = eff_length(i_fin.proto, i_fin.ulen);

    // Three-term ones'-complement add: fold the carries back twice
    assign w_sum3  = {2'd0, i_fin.sum} + {2'd0, i_fin.ulen} + {10'd0, i_fin.proto};
    assign w_fold1 = {1'b0, w_sum3[15:0]} + {15'd0, w_sum3[17:16]};
    assign w_fold2 = w_fold1[15:0] + {15'd0, w_fold1[16]};
    assign w_calc  = ~w_fold2;

    always_comb begin
        n_res = '0;
        w_ok  = (i_fin.rsum == w_calc) || (i_fin.rsum == SUM_ONES && w_calc == SUM_ZERO);
        if (i_fin.total < {1'b0, HDR_LEN}) begin
            n_res.status = ST_TRUNCATED;
        end else if (!w_udp && !w_icmp) begin
            n_res.status = ST_UNSUPPORTED;
        end else if (i_fin.total < ({1'b0, HDR_LEN} + {2'd0, w_eff})) begin
            n_res.status = ST_TRUNCATED;
        end else if (w_udp) begin
            // UDP reserves zero for "no checksum"
            if (i_fin.rsum == SUM_ZERO) begin
                w_ok = 1'b0;
            end
            n_res.fill_value  = (w_calc == SUM_ZERO) ? SUM_ONES : w_calc;
            n_res.fill_offset = UDP_CSUM_POS;
            n_res.is_udp      = 1'b1;
            n_res.status      = w_ok ? ST_OK : ST_MISMATCH;
        end else begin
            n_res.fill_value  = w_calc;
            n_res.fill_offset = ICMP_CSUM_POS;
            n_res.status      = w_ok ? ST_OK : ST_MISMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_valid <= i_fin_valid;
        end
        if (o_fin_ready && i_fin_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

[sv/ipv6_l4_checksum_check_fill.sv]
// Top level of the IPv6 UDP/ICMPv6 checksum checker: stream ports and result packing.
// Instantiates ip6cs_accum and ip6cs_result; uses ip6cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes an IPv6 packet one byte per cycle from the first header byte, with
// tlast on the final byte, and returns one result per packet: status, the
// checksum to write back and its byte offset, plus an is-UDP flag in tuser.
// Bytes are accepted back to back at one per cycle with no gaps between
// packets while the output side keeps up; that rate is set by the per-byte
// running-sum add with its end-around carry fold. The result is registered;
// the last byte goes through the input and snapshot registers to the output
// register. Up to two finished results are held while the output side stalls
// before input is pushed back. There is no start-up pass after reset.
module ipv6_l4_checksum_check_fill (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [1:0] status, [17:2] fill_value,
                                          // [23:18] fill_offset
    output logic        o_m_axis_tuser    // is_udp
);
    import ip6cs_pkg::*;

    logic  w_fin_valid;
    logic  w_fin_ready;
    t_fin  w_fin;
    t_res  w_res;

    ip6cs_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_fin_valid (w_fin_valid),
        .i_fin_ready (w_fin_ready),
        .o_fin       (w_fin)
    );

    ip6cs_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .o_fin_ready (w_fin_ready),
        .i_fin       (w_fin),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (w_res)
    );

    assign o_m_axis_tdata = {w_res.fill_offset, w_res.fill_value, w_res.status};
    assign o_m_axis_tuser = w_res.is_udp;

    // Error results carry no fill information
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] == ST_UNSUPPORTED ||
                            o_m_axis_tdata[1:0] == ST_TRUNCATED)
        |-> o_m_axis_tdata[23:2] == 22'd0 && !o_m_axis_tuser)
        else $error("error result with non-zero fill fields");

    // UDP never fills zero and always points at the UDP checksum
    a_udp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser
        |-> o_m_axis_tdata[17:2] != SUM_ZERO && o_m_axis_tdata[23:18] == UDP_CSUM_POS)
        else $error("UDP result with zero fill or wrong offset");

    // Checked ICMPv6 results point at the ICMPv6 checksum
    a_icmp_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser &&
        (o_m_axis_tdata[1:0] == ST_OK || o_m_axis_tdata[1:0] == ST_MISMATCH)
        |-> o_m_axis_tdata[23:18] == ICMP_CSUM_POS)
        else $error("ICMPv6 result with wrong offset");

endmodule

`default_nettype wire

[verif/tb_ipv6_l4_checksum_check_fill.sv]
// Self-checking testbench for ipv6_l4_checksum_check_fill: byte stream in, one verdict per packet.
// Packets are predicted in the bench itself; depends only on ip6cs_pkg and the top level.
`timescale 1ns / 1ps

module tb_ipv6_l4_checksum_check_fill;
    import ip6cs_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int HDR_BYTES   = 40;

    typedef enum int {
        SEAL_NONE,          // leave the random checksum bytes
        SEAL_GOOD,          // write the correct checksum
        SEAL_ZERO,          // write zero
        SEAL_ONES,          // write all ones
        SEAL_CALC_ZERO,     // steer the sum so the computed checksum is zero, then seal
        SEAL_CALC_ZERO_ONES // as above, but write all ones
    } t_seal;

    // Running checksum state of one packet in flight
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       proto;
        logic [15:0]      ulen;
        logic [15:0]      sum;
        logic [7:0]       held;
        logic [15:0]      rsum;
    } t_csum_state;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    t_csum_state pkt_state = '0;
    t_res        verdict_q[$];
    logic [7:0]  pkt_buf[$];

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int n_errors = 0;
    int n_bytes = 0;
    int n_packets = 0;
    int n_results = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    ipv6_l4_checksum_check_fill u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, v};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Upper-layer bytes covered by the sum: never fewer than the header holding the checksum
    function automatic logic [15:0] covered_len(input t_csum_state st);
        logic [15:0] floor_len;
        floor_len = (st.proto == PROTO_UDP) ? UDP_MIN_LEN : ICMP_MIN_LEN;
        return (st.ulen < floor_len) ? floor_len : st.ulen;
    endfunction

    // Advance the packet state by one byte; returns 1 with the verdict on the last byte
    function automatic bit csum_advance(inout t_csum_state st, input logic [7:0] b,
                                        input logic last, output t_res verdict);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] cpos;
        logic [POS_W:0]   total;
        logic [15:0]      word;
        logic [15:0]      s;
        logic [15:0]      calc;
        bit               udp;
        bit               icmp;
        bit               ok;
        p = st.pos;
        udp = (st.proto == PROTO_UDP);
        icmp = (st.proto == PROTO_ICMP6);
        word = p[0] ? {8'h00, b} : {b, 8'h00};
        verdict = '0;
        if (p == POS_PLEN_HI) begin
            st.held = b;
        end else if (p == POS_PLEN_LO) begin
            st.ulen = {st.held, b};
        end else if (p == POS_NEXT_HDR) begin
            st.proto = b;
        end else if (p >= ADDR_START && p < HDR_LEN) begin
            st.sum = ones_add(st.sum, word);
        end else if (p >= HDR_LEN && (udp || icmp)) begin
            cpos = udp ? {11'd0, UDP_CSUM_POS} : {11'd0, ICMP_CSUM_POS};
            // UDP replaces the length with its own header field
            if (udp && p == POS_UDP_LEN_HI) begin
                st.held = b;
            end else if (udp && p == POS_UDP_LEN_LO) begin
                st.ulen = {st.held, b};
            end
            if (p == cpos) begin
                st.rsum[15:8] = b;
            end else if (p == cpos + 17'd1) begin
                st.rsum[7:0] = b;
            end else if ((p - HDR_LEN) < {1'b0, covered_len(st)}) begin
                st.sum = ones_add(st.sum, word);
            end
        end
        if (p != POS_MAX) st.pos = p + 17'd1;
        if (!last) return 1'b0;

        total = {1'b0, p} + 18'd1;
        udp = (st.proto == PROTO_UDP);
        icmp = (st.proto == PROTO_ICMP6);
        if (total < {1'b0, HDR_LEN}) begin
            verdict.status = ST_TRUNCATED;
        end else if (!udp && !icmp) begin
            verdict.status = ST_UNSUPPORTED;
        end else if (total < {1'b0, HDR_LEN} + {2'b00, covered_len(st)}) begin
            verdict.status = ST_TRUNCATED;
        end else begin
            s = ones_add(ones_add(st.sum, st.ulen), {8'h00, st.proto});
            calc = ~s;
            ok = (st.rsum == calc) || (st.rsum == SUM_ONES && calc == SUM_ZERO);
            if (udp) begin
                verdict.fill_value = (calc == SUM_ZERO) ? SUM_ONES : calc;
                if (st.rsum == SUM_ZERO) ok = 1'b0;
                verdict.fill_offset = UDP_CSUM_POS;
                verdict.is_udp = 1'b1;
            end else begin
                verdict.fill_value = calc;
                verdict.fill_offset = ICMP_CSUM_POS;
            end
            verdict.status = ok ? ST_OK : ST_MISMATCH;
        end
        st = '0;
        return 1'b1;
    endfunction

    // Verdict the block should give for the packet now in pkt_buf
    function automatic t_res scratch_verdict();
        t_csum_state st;
        t_res        r;
        st = '0;
        r = '0;
        for (int i = 0; i < pkt_buf.size(); i++)
            void'(csum_advance(st, pkt_buf[i], i == pkt_buf.size() - 1, r));
        return r;
    endfunction

    task automatic build_packet(input logic [7:0] nh, input logic [15:0] plen,
                                input logic [15:0] udp_len, input int n_upper);
        pkt_buf.delete();
        repeat (HDR_BYTES + n_upper) pkt_buf.push_back(8'($urandom_range(0, 255)));
        pkt_buf[4] = plen[15:8];
        pkt_buf[5] = plen[7:0];
        pkt_buf[6] = nh;
        if (nh == PROTO_UDP && n_upper >= 6) begin
            pkt_buf[44] = udp_len[15:8];
            pkt_buf[45] = udp_len[7:0];
        end
    endtask

    task automatic trim_packet(input int n);
        while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
    endtask

    task automatic seal_packet(input t_seal mode);
        int          cpos;
        t_res        r;
        logic [15:0] w;
        logic [15:0] fill;
        if (mode == SEAL_NONE || pkt_buf.size() <= int'(POS_NEXT_HDR)) return;
        cpos = (pkt_buf[6] == PROTO_UDP) ? int'(UDP_CSUM_POS) : int'(ICMP_CSUM_POS);
        if (pkt_buf.size() < cpos + 2) return;
        r = scratch_verdict();
        if (r.status != ST_OK && r.status != ST_MISMATCH) return;
        if (mode == SEAL_CALC_ZERO || mode == SEAL_CALC_ZERO_ONES) begin
            // add the complement into an address word so the final sum is all ones
            w = ones_add({pkt_buf[8], pkt_buf[9]}, r.fill_value);
            pkt_buf[8] = w[15:8];
            pkt_buf[9] = w[7:0];
            r = scratch_verdict();
        end
        case (mode)
            SEAL_ZERO:           fill = SUM_ZERO;
            SEAL_ONES:           fill = SUM_ONES;
            SEAL_CALC_ZERO_ONES: fill = SUM_ONES;
            default:             fill = r.fill_value;
        endcase
        pkt_buf[cpos] = fill[15:8];
        pkt_buf[cpos + 1] = fill[7:0];
    endtask

    // Offer one byte, hold it until accepted, then predict
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_res r;
        while (src_idle && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_bytes++;
        if (csum_advance(pkt_state, b, last, r)) verdict_q.push_back(r);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++)
            send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
        n_packets++;
    endtask

    task automatic send_built(input logic [7:0] nh, input logic [15:0] plen,
                              input logic [15:0] udp_len, input int n_upper,
                              input t_seal mode);
        build_packet(nh, plen, udp_len, n_upper);
        seal_packet(mode);
        send_packet();
    endtask

    task automatic test_directed_cases();
        send_built(PROTO_UDP, 16'd12, 16'd12, 12, SEAL_GOOD);
        send_built(PROTO_ICMP6, 16'd9, 16'd0, 9, SEAL_GOOD);      // odd length, padded
        send_built(PROTO_UDP, 16'd8, 16'd8, 8, SEAL_NONE);
        send_built(PROTO_ICMP6, 16'd4, 16'd0, 4, SEAL_NONE);
        send_built(PROTO_UDP, 16'd10, 16'd10, 10, SEAL_ZERO);     // received zero on UDP
        send_built(PROTO_UDP, 16'd16, 16'd16, 16, SEAL_CALC_ZERO);
        send_built(PROTO_ICMP6, 16'd6, 16'd0, 6, SEAL_CALC_ZERO);
        send_built(PROTO_ICMP6, 16'd6, 16'd0, 6, SEAL_CALC_ZERO_ONES);
        send_built(PROTO_UDP, 16'd0, 16'd0, 8, SEAL_GOOD);        // length below the floor
        send_built(PROTO_ICMP6, 16'd0, 16'd0, 4, SEAL_GOOD);
        send_built(PROTO_UDP, 16'd10, 16'd20, 20, SEAL_GOOD);     // UDP length wins
        send_built(PROTO_UDP, 16'd8, 16'd8, 30, SEAL_GOOD);       // trailing bytes ignored
        send_built(8'd6, 16'd20, 16'd0, 20, SEAL_NONE);
        send_built(8'd0, 16'd0, 16'd0, 2, SEAL_NONE);
        send_built(8'd255, 16'hFFFF, 16'd0, 8, SEAL_NONE);
        send_built(PROTO_UDP, 16'd20, 16'd20, 19, SEAL_NONE);     // payload one short
        send_built(PROTO_UDP, 16'd8, 16'd8, 0, SEAL_NONE);        // bare header
        build_packet(PROTO_UDP, 16'd8, 16'd8, 0);
        trim_packet(1);
        send_packet();
        build_packet(PROTO_ICMP6, 16'd4, 16'd0, 0);
        trim_packet(HDR_BYTES - 1);
        send_packet();
        // all-zero and all-ones bytes
        build_packet(8'd0, 16'd0, 16'd0, 8);
        foreach (pkt_buf[i]) pkt_buf[i] = 8'h00;
        send_packet();
        build_packet(8'd255, 16'd0, 16'd0, 8);
        foreach (pkt_buf[i]) pkt_buf[i] = 8'hFF;
        send_packet();
    endtask

    // Stall the output long enough that the block backs up into its input
    task automatic test_output_stall();
        src_idle = 1'b0;
        hold_req <= hold_req + 1;
        repeat (40) begin
            build_packet(PROTO_UDP, 16'd8, 16'd8, 0);
            trim_packet($urandom_range(1, 3));
            send_packet();
        end
        src_idle = 1'b1;
    endtask

    task automatic send_random_packet();
        int          kind;
        int          need;
        int          n_upper;
        int          pick;
        logic [7:0]  nh;
        logic [15:0] plen;
        logic [15:0] udp_len;
        t_seal       mode;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            nh = $urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP6;
            case ($urandom_range(0, 9))
                0:       plen = 16'($urandom_range(0, 200));
                1:       plen = 16'($urandom_range(0, 65535));
                default: plen = 16'($urandom_range(0, 40));
            endcase
            udp_len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 48)) : plen;
            if (nh == PROTO_UDP) need = (udp_len < 16'd8) ? 8 : int'(udp_len);
            else need = (plen < 16'd4) ? 4 : int'(plen);
            if (need > 300 || $urandom_range(0, 9) == 0)
                n_upper = $urandom_range(0, (need > 60 ? 60 : need - 1));
            else if ($urandom_range(0, 9) < 3)
                n_upper = need + $urandom_range(1, 4);
            else
                n_upper = need;
            pick = $urandom_range(0, 99);
            if (pick < 55)      mode = SEAL_GOOD;
            else if (pick < 70) mode = SEAL_NONE;
            else if (pick < 80) mode = SEAL_ZERO;
            else if (pick < 85) mode = SEAL_ONES;
            else if (pick < 95) mode = SEAL_CALC_ZERO;
            else                mode = SEAL_CALC_ZERO_ONES;
            send_built(nh, plen, udp_len, n_upper, mode);
        end else if (kind < 85) begin
            nh = 8'($urandom_range(0, 255));
            send_built(nh, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 65535)),
                       $urandom_range(0, 30), SEAL_NONE);
        end else begin
            build_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'd0, 0);
            trim_packet($urandom_range(1, HDR_BYTES - 1));
            send_packet();
        end
    endtask

    task automatic test_random_traffic();
        int first_byte;
        first_byte = n_bytes;
        while (n_bytes - first_byte < 150)
            send_random_packet();
    endtask

    // Bytes and results flow with no idle cycles on either side
    task automatic test_no_idle_burst();
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        send_built(PROTO_UDP, 16'd12, 16'd12, 12, SEAL_GOOD);
        send_built(PROTO_ICMP6, 16'd12, 16'd0, 12, SEAL_GOOD);
        build_packet(PROTO_UDP, 16'd8, 16'd8, 0);
        trim_packet(2);
        send_packet();
        send_built(PROTO_UDP, 16'd12, 16'd12, 12, SEAL_NONE);
        src_idle = 1'b1;
        sink_idle <= 1'b1;
    endtask

    // Receiver: random stalls, with a counted hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (sink_idle) begin
            m_tready <= ($urandom_range(0, 99) >= 36);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                want = verdict_q.pop_front();
                n_results++;
                status_seen[want.status]++;
                if (m_tdata[1:0] != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[1:0]);
                    n_errors++;
                end
                if (m_tdata[17:2] != want.fill_value) begin
                    $display("%0t: fill_value expected %h actual %h",
                             $time, want.fill_value, m_tdata[17:2]);
                    n_errors++;
                end
                if (m_tdata[23:18] != want.fill_offset) begin
                    $display("%0t: fill_offset expected %0d actual %0d",
                             $time, want.fill_offset, m_tdata[23:18]);
                    n_errors++;
                end
                if (m_tuser != want.is_udp) begin
                    $display("%0t: is_udp expected %b actual %b",
                             $time, want.is_udp, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, verdict_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_output_stall();
        test_random_traffic();
        test_no_idle_burst();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (verdict_q.size() != 0) n_errors++;
        $display("Covered %0d packets (%0d bytes), %0d verdicts checked, incl. a long output",
                 n_packets, n_bytes, n_results);
        $display("hold-off and a no-idle burst; ok %0d, mismatch %0d, unsupported %0d, short %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ip6cs_pkg.sv
sv/ip6cs_accum.sv
sv/ip6cs_result.sv
sv/ipv6_l4_checksum_check_fill.sv
verif/tb_ipv6_l4_checksum_check_fill.sv
